/* rtl/core/kprh_pkg.sv */
// Shared types and constants for the keypad repeat/hold classifier.
`default_nettype none
package kprh_pkg;

  localparam int TIME_W  = 32;
  localparam int DELAY_W = 16;
  localparam int NUM_KEYS = 4;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;

  localparam logic [1:0] KEY_UP     = 2'd0;
  localparam logic [1:0] KEY_SELECT = 2'd1;
  localparam logic [1:0] KEY_DOWN   = 2'd2;
  localparam logic [1:0] KEY_POWER  = 2'd3;

  localparam logic OP_EDGE = 1'b0;
  localparam logic OP_POLL = 1'b1;

  localparam logic [1:0] REG_FIRST_REPEAT = 2'd0;
  localparam logic [1:0] REG_FAST_REPEAT  = 2'd1;
  localparam logic [1:0] REG_HOLD         = 2'd2;

  localparam logic [DELAY_W-1:0] RESET_FIRST_REPEAT_MS = 16'd500;
  localparam logic [DELAY_W-1:0] RESET_FAST_REPEAT_MS  = 16'd300;
  localparam logic [DELAY_W-1:0] RESET_HOLD_MS         = 16'd500;

  typedef enum logic [2:0] {
    EV_NONE        = 3'd0,
    EV_COMBO       = 3'd1,
    EV_UP          = 3'd2,
    EV_DOWN        = 3'd3,
    EV_MENU_SHORT  = 3'd4,
    EV_MENU_HELD   = 3'd5,
    EV_POWER_SHORT = 3'd6,
    EV_POWER_HELD  = 3'd7
  } key_event_t;

  typedef struct packed {
    logic [DELAY_W-1:0] first_repeat_ms;
    logic [DELAY_W-1:0] fast_repeat_ms;
    logic [DELAY_W-1:0] hold_ms;
  } kprh_cfg_t;

  typedef struct packed {
    logic [NUM_KEYS-1:0][TIME_W-1:0] press_time;
    logic                            repeat_flag;
    logic [DELAY_W-1:0]              repeat_delay;
  } kprh_state_t;

endpackage
`default_nettype wire

/* rtl/core/kprh_eval.sv */
// Combinational evaluation of one request against the key state.
`default_nettype none
module kprh_eval (
  input  wire logic                       opcode,
  input  wire logic [1:0]                 key_index,
  input  wire logic [kprh_pkg::TIME_W-1:0] now_ms,
  input  wire logic [3:0]                 key_levels,
  input  wire kprh_pkg::kprh_cfg_t        cfg,
  input  wire kprh_pkg::kprh_state_t      st,
  output kprh_pkg::kprh_state_t           st_nxt,
  output kprh_pkg::key_event_t            key_event
);
  import kprh_pkg::*;

  logic [NUM_KEYS-1:0][TIME_W-1:0] elapsed;
  logic [NUM_KEYS-1:0]             has_press;
  logic                            done;
  logic                            lv_up, lv_menu, lv_down, lv_power;

  assign lv_up    = key_levels[KEY_UP];
  assign lv_menu  = key_levels[KEY_SELECT];
  assign lv_down  = key_levels[KEY_DOWN];
  assign lv_power = key_levels[KEY_POWER];

  always_comb begin
    for (int k = 0; k < NUM_KEYS; k++) begin
      elapsed[k]   = now_ms - st.press_time[k];
      has_press[k] = (st.press_time[k] != '0);
    end
  end

  always_comb begin
    st_nxt    = st;
    key_event = EV_NONE;
    done      = 1'b0;
    if (opcode == OP_EDGE) begin
      st_nxt.press_time[key_index] = now_ms;
    end else if (lv_up && lv_down) begin
      key_event = EV_COMBO;
    end else begin
      // up: repeat or release
      if (lv_up) begin
        if (has_press[KEY_UP] &&
            elapsed[KEY_UP] > {{(TIME_W-DELAY_W){1'b0}}, st_nxt.repeat_delay}) begin
          st_nxt.repeat_flag = 1'b1;
          st_nxt.press_time[KEY_UP] = st.press_time[KEY_UP] +
            {{(TIME_W-DELAY_W){1'b0}}, st_nxt.repeat_delay};
          st_nxt.repeat_delay = cfg.fast_repeat_ms;
          key_event = EV_UP;
          done = 1'b1;
        end
      end else if (has_press[KEY_UP]) begin
        st_nxt.press_time[KEY_UP] = '0;
        if (!st_nxt.repeat_flag) begin
          key_event = EV_UP;
          done = 1'b1;
        end else begin
          st_nxt.repeat_flag  = 1'b0;
          st_nxt.repeat_delay = cfg.first_repeat_ms;
        end
      end
      // down: repeat or release
      if (!done) begin
        if (lv_down) begin
          if (has_press[KEY_DOWN] &&
              elapsed[KEY_DOWN] > {{(TIME_W-DELAY_W){1'b0}}, st_nxt.repeat_delay}) begin
            st_nxt.repeat_flag = 1'b1;
            st_nxt.press_time[KEY_DOWN] = st.press_time[KEY_DOWN] +
              {{(TIME_W-DELAY_W){1'b0}}, st_nxt.repeat_delay};
            st_nxt.repeat_delay = cfg.fast_repeat_ms;
            key_event = EV_DOWN;
            done = 1'b1;
          end
        end else if (has_press[KEY_DOWN]) begin
          st_nxt.press_time[KEY_DOWN] = '0;
          if (!st_nxt.repeat_flag) begin
            key_event = EV_DOWN;
            done = 1'b1;
          end else begin
            st_nxt.repeat_flag  = 1'b0;
            st_nxt.repeat_delay = cfg.first_repeat_ms;
          end
        end
      end
      // menu: release, then hold
      if (!done && !lv_menu && has_press[KEY_SELECT]) begin
        st_nxt.press_time[KEY_SELECT] = '0;
        if (!st_nxt.repeat_flag) begin
          key_event = EV_MENU_SHORT;
          done = 1'b1;
        end else begin
          st_nxt.repeat_flag  = 1'b0;
          st_nxt.repeat_delay = cfg.first_repeat_ms;
        end
      end
      if (!done && !st_nxt.repeat_flag && lv_menu && has_press[KEY_SELECT] &&
          elapsed[KEY_SELECT] > {{(TIME_W-DELAY_W){1'b0}}, cfg.hold_ms}) begin
        st_nxt.repeat_flag = 1'b1;
        key_event = EV_MENU_HELD;
        done = 1'b1;
      end
      // power: release, then hold
      if (!done && !lv_power && has_press[KEY_POWER]) begin
        st_nxt.press_time[KEY_POWER] = '0;
        if (!st_nxt.repeat_flag) begin
          key_event = EV_POWER_SHORT;
          done = 1'b1;
        end else begin
          st_nxt.repeat_flag  = 1'b0;
          st_nxt.repeat_delay = cfg.first_repeat_ms;
        end
      end
      if (!done && !st_nxt.repeat_flag && lv_power && has_press[KEY_POWER] &&
          elapsed[KEY_POWER] > {{(TIME_W-DELAY_W){1'b0}}, cfg.hold_ms}) begin
        st_nxt.repeat_flag = 1'b1;
        key_event = EV_POWER_HELD;
      end
    end
  end

endmodule
`default_nettype wire

/* rtl/core/key_press_repeat_hold_classifier_top.sv */
// Top level of the keypad repeat/hold classifier with its register port.
`default_nettype none
// Four-key handler (up, menu, down, power). Edge requests (opcode 0) record the
// press time of one key and return event 0; poll requests (opcode 1) return one
// event in fixed priority: combo, up, down, menu short, menu held, power short,
// power held. One request is taken every cycle unless the output stalls; each
// request passes an input register and is evaluated against the key state; on
// advancing it updates the key state and loads the result register. The
// result register and the input register let a new request enter while a
// result waits. Registers: 0x0 first repeat delay, 0x4 fast repeat interval,
// 0x8 hold time, each 16 bits in ms; write them only while the block is idle.
module key_press_repeat_hold_classifier_top (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic                          in_opcode,
  input  wire logic [1:0]                    in_key_index,
  input  wire logic [kprh_pkg::TIME_W-1:0]   in_now_ms,
  input  wire logic [3:0]                    in_key_levels,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [2:0]                         out_key_event,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [kprh_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [kprh_pkg::DATA_W-1:0]   pwdata,
  output logic [kprh_pkg::DATA_W-1:0]        prdata,
  output logic                               pready
);
  import kprh_pkg::*;

  kprh_cfg_t   cfg_r;
  kprh_state_t st_r;
  kprh_state_t st_nxt;
  key_event_t  ev_nxt;

  logic              in_valid_r;
  logic              opcode_r;
  logic [1:0]        key_index_r;
  logic [TIME_W-1:0] now_ms_r;
  logic [3:0]        key_levels_r;
  logic              out_valid_r;
  logic [2:0]        out_key_event_r;
  logic              advance;
  logic              cfg_wr;

  assign advance   = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || advance;
  assign out_valid = out_valid_r;
  assign out_key_event = out_key_event_r;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite;

  always_comb begin
    case (paddr[3:2])
      REG_FIRST_REPEAT: prdata = {{(DATA_W-DELAY_W){1'b0}}, cfg_r.first_repeat_ms};
      REG_FAST_REPEAT:  prdata = {{(DATA_W-DELAY_W){1'b0}}, cfg_r.fast_repeat_ms};
      REG_HOLD:         prdata = {{(DATA_W-DELAY_W){1'b0}}, cfg_r.hold_ms};
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.first_repeat_ms <= RESET_FIRST_REPEAT_MS;
      cfg_r.fast_repeat_ms  <= RESET_FAST_REPEAT_MS;
      cfg_r.hold_ms         <= RESET_HOLD_MS;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_FIRST_REPEAT: cfg_r.first_repeat_ms <= pwdata[DELAY_W-1:0];
        REG_FAST_REPEAT:  cfg_r.fast_repeat_ms  <= pwdata[DELAY_W-1:0];
        REG_HOLD:         cfg_r.hold_ms         <= pwdata[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  kprh_eval u_eval (
    .opcode     (opcode_r),
    .key_index  (key_index_r),
    .now_ms     (now_ms_r),
    .key_levels (key_levels_r),
    .cfg        (cfg_r),
    .st         (st_r),
    .st_nxt     (st_nxt),
    .key_event  (ev_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
      st_r.press_time <= '0;
      st_r.repeat_flag <= 1'b0;
      st_r.repeat_delay <= RESET_FIRST_REPEAT_MS;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        st_r        <= st_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      opcode_r     <= in_opcode;
      key_index_r  <= in_key_index;
      now_ms_r     <= in_now_ms;
      key_levels_r <= in_key_levels;
    end
    if (advance) begin
      out_key_event_r <= ev_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !in_valid_r && !out_valid_r)
    else $error("pipeline not empty after reset");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !advance |=> $stable(st_r))
    else $error("key state changed without a request");

  a_edge_none: assert property (@(posedge clk) disable iff (!rst_n)
    advance && opcode_r == OP_EDGE |=> out_key_event_r == EV_NONE)
    else $error("edge request produced an event");

  a_combo_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    advance && opcode_r == OP_POLL && key_levels_r[KEY_UP] && key_levels_r[KEY_DOWN]
      |=> $stable(st_r) && out_key_event_r == EV_COMBO)
    else $error("combo altered state or missed");
`endif

endmodule
`default_nettype wire
